// ===== rtl/core/srcu_pkg.sv =====
// Shared types, constants and microcode encoding for the send-rate update block.
// No dependencies; imported by every module of the block except srcu_divider.
package srcu_pkg;

   localparam int DEF_RATE_FRAC_BITS = 16;

   localparam int MICRO_W      = 20;
   localparam logic [MICRO_W-1:0] MICRO = 20'd1000000;
   localparam int RATE_W       = 32;
   localparam int SPACING_W    = 32;
   localparam int SPACING_FRAC = 8;
   localparam int QUEUE_W      = 20;
   localparam int GAIN_W       = 16;
   localparam int GAIN_FRAC    = 12;
   localparam int STEPSZ_W     = 10;
   localparam int DECF_W       = 12;
   localparam int INIT_W       = 20;

   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 20;
   localparam int REQ_DATA_W   = 64;
   localparam int RSP_DATA_W   = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_CONTROL_MODE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_STEP       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECREASE_FACTOR = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUEUE_GAIN      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLAYBACK_GAIN   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_SPACING = 3'd5;

   localparam logic [STEPSZ_W-1:0]  RATE_STEP_RST  = 10'd1;
   localparam logic [DECF_W-1:0]    DECF_RST       = 12'd2048;
   localparam logic [GAIN_W-1:0]    QGAIN_RST      = 16'd410;
   localparam logic [GAIN_W-1:0]    PGAIN_RST      = 16'd4506;
   localparam logic [INIT_W-1:0]    INIT_SPACING_RST = 20'd90000;
   localparam logic [SPACING_W-1:0] SPACING_RST    =
      {{(SPACING_W-INIT_W-SPACING_FRAC){1'b0}}, INIT_SPACING_RST, {SPACING_FRAC{1'b0}}};

   typedef enum logic [1:0] {
      MODE_ADD,
      MODE_AIMD,
      MODE_PROP,
      MODE_PROP_PLAY
   } mode_type;

   typedef enum logic [2:0] {
      OP_WAIT_IN,
      OP_DIV,
      OP_MUL,
      OP_COMBINE,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      DIV_CUR,
      DIV_PLAY,
      DIV_NEW
   } div_sel_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_QERR,
      MUL_PERR,
      MUL_DEC
   } mul_sel_type;

   typedef enum logic [1:0] {
      WB_NONE,
      WB_EMAG,
      WB_BMAG,
      WB_DEC
   } wb_sel_type;

   localparam int STEP_W = 4;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_IDLE      = 4'd0;
   localparam step_type STEP_DIV_CUR   = 4'd1;
   localparam step_type STEP_DIV_PLAY  = 4'd2;
   localparam step_type STEP_MUL_QERR  = 4'd3;
   localparam step_type STEP_MUL_PERR  = 4'd4;
   localparam step_type STEP_MUL_DEC   = 4'd5;
   localparam step_type STEP_WB_DEC    = 4'd6;
   localparam step_type STEP_COMBINE   = 4'd7;
   localparam step_type STEP_DIV_NEW   = 4'd8;
   localparam step_type STEP_EMIT      = 4'd9;

   typedef struct packed {
      op_type      op;
      div_sel_type div_sel;
      mul_sel_type mul_sel;
      wb_sel_type  wb_sel;
      step_type    jump;
   } ucode_type;

endpackage

// ===== rtl/core/srcu_ucode_rom.sv =====
// Control store: one control word per program step of the rate update sequence.
// Depends on srcu_pkg.
module srcu_ucode_rom (
   input  srcu_pkg::step_type  step,
   output srcu_pkg::ucode_type ucode
);
   import srcu_pkg::*;

   always_comb begin
      ucode = '{op: OP_WAIT_IN, div_sel: DIV_CUR, mul_sel: MUL_NONE, wb_sel: WB_NONE,
                jump: STEP_IDLE};
      unique case (step)
         STEP_IDLE: begin
            ucode.op = OP_WAIT_IN;
         end
         STEP_DIV_CUR: begin
            ucode.op      = OP_DIV;
            ucode.div_sel = DIV_CUR;
         end
         STEP_DIV_PLAY: begin
            ucode.op      = OP_DIV;
            ucode.div_sel = DIV_PLAY;
         end
         STEP_MUL_QERR: begin
            ucode.op      = OP_MUL;
            ucode.mul_sel = MUL_QERR;
         end
         STEP_MUL_PERR: begin
            ucode.op      = OP_MUL;
            ucode.mul_sel = MUL_PERR;
            ucode.wb_sel  = WB_EMAG;
         end
         STEP_MUL_DEC: begin
            ucode.op      = OP_MUL;
            ucode.mul_sel = MUL_DEC;
            ucode.wb_sel  = WB_BMAG;
         end
         STEP_WB_DEC: begin
            ucode.op      = OP_MUL;
            ucode.wb_sel  = WB_DEC;
         end
         STEP_COMBINE: begin
            ucode.op   = OP_COMBINE;
            ucode.jump = STEP_EMIT;
         end
         STEP_DIV_NEW: begin
            ucode.op      = OP_DIV;
            ucode.div_sel = DIV_NEW;
         end
         STEP_EMIT: begin
            ucode.op   = OP_EMIT;
            ucode.jump = STEP_IDLE;
         end
         default: begin
            ucode.op = OP_WAIT_IN;
         end
      endcase
   end

endmodule

// ===== rtl/core/srcu_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by all reciprocal steps.
// Depends on srcu_pkg only through the instantiating module's widths.
module srcu_divider #(
   parameter int DIVIDEND_W = 44,
   parameter int DIVISOR_W  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);
   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = trial - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         rem_in  = '0;
         den_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/send_rate_congestion_update.sv =====
// Top level of the send-rate update: config registers, microcode sequencer and datapath.
// Depends on srcu_pkg, srcu_ucode_rom and srcu_divider.
//
//   channel | ports                          | beat carries
//   req     | req_tvalid/tready/tdata        | one feedback report
//   rsp     | rsp_tvalid/tready/tdata/tuser  | new spacing, rate and floor flag
//   csr     | csr_valid/ready/index/data     | one register write
//
// Each report runs the bit-serial divider for three reciprocals (two when the rate is
// unchanged or floored); its dividend is 28+RATE_FRAC_BITS bits wide.
// Reset is synchronous; it loads register defaults and spacing = 90000 us.
// The result sits in an output register; a new report is taken while it waits,
// and the sequence holds at its last step only if that register is still full.
module send_rate_congestion_update #(
   parameter int RATE_FRAC_BITS = srcu_pkg::DEF_RATE_FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [19:0] queue_now, [39:20] queue_target, [59:40] playback_spacing
   input  logic [srcu_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [31:0] spacing_us, [63:32] rate_pps
   output logic [srcu_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [0] rate_floored
   output logic                               rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [srcu_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [srcu_pkg::CSR_DATA_W-1:0]    csr_data
);
   import srcu_pkg::*;

   localparam int NUM_W   = MICRO_W + SPACING_FRAC + RATE_FRAC_BITS;
   localparam int QPROD_W = GAIN_W + QUEUE_W;
   localparam int E_W     = QPROD_W + RATE_FRAC_BITS - GAIN_FRAC;
   localparam int PROD_W  = GAIN_W + RATE_W;
   localparam int B_W     = PROD_W - GAIN_FRAC;
   localparam int MAXEB_W = (E_W > B_W) ? E_W : B_W;
   localparam int ACC_W   = MAXEB_W + 3;

   localparam logic [NUM_W-1:0] NUM_SPACING =
      NUM_W'(MICRO) << (SPACING_FRAC + RATE_FRAC_BITS);
   localparam logic [NUM_W-1:0] NUM_PLAY = NUM_W'(MICRO) << RATE_FRAC_BITS;

   // config registers
   mode_type            mode_ff;
   logic [STEPSZ_W-1:0] rate_step_ff;
   logic [DECF_W-1:0]   decf_ff;
   logic [GAIN_W-1:0]   qgain_ff;
   logic [GAIN_W-1:0]   pgain_ff;
   logic [INIT_W-1:0]   init_sp_ff;

   // sequencer
   step_type  step_ff, step_in;
   ucode_type uc;
   logic      div_run_ff, div_run_in;
   logic      div_start, div_done;
   logic [NUM_W-1:0]  div_quo;
   logic [NUM_W-1:0]  div_dividend;
   logic [RATE_W-1:0] div_divisor;
   logic [RATE_W-1:0] quo_sat;
   logic      in_beat, emit_ok, emit_fire;

   // datapath
   logic [QUEUE_W-1:0]   qnow_ff, qtgt_ff, pspace_ff;
   logic [SPACING_W-1:0] spacing_ff, spacing_in;
   logic [RATE_W-1:0]    cur_ff, cur_in;
   logic [RATE_W-1:0]    prate_ff, prate_in;
   logic [PROD_W-1:0]    prod_ff;
   logic [GAIN_W-1:0]    mul_a;
   logic [RATE_W-1:0]    mul_b;
   logic [E_W-1:0]       emag_ff, emag_in;
   logic [B_W-1:0]       bmag_ff, bmag_in;
   logic [RATE_W-1:0]    dec_ff, dec_in;
   logic [RATE_W-1:0]    res_rate_ff, res_rate_in;
   logic                 res_flag_ff, res_flag_in;
   logic [QPROD_W+RATE_FRAC_BITS-1:0] e_wide;
   logic                 q_less, q_more, cur_below;
   logic signed [ACC_W-1:0] acc, cur_ext, step_ext, e_ext, b_ext, dec_ext;
   logic                 change, floored;
   logic [RATE_W-1:0]    nr;

   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [SPACING_W-1:0] rsp_spacing_ff;
   logic [RATE_W-1:0]    rsp_rate_ff;
   logic                 rsp_flag_ff;

   srcu_ucode_rom u_rom (
      .step  (step_ff),
      .ucode (uc)
   );

   srcu_divider #(
      .DIVIDEND_W (NUM_W),
      .DIVISOR_W  (RATE_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign csr_ready  = !reset;
   assign req_tready = !reset && (uc.op == OP_WAIT_IN);
   assign in_beat    = req_tvalid && req_tready;
   assign emit_ok    = !rsp_tvalid_ff || rsp_tready;
   assign emit_fire  = (uc.op == OP_EMIT) && emit_ok;
   assign div_start  = (uc.op == OP_DIV) && !div_run_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_ADD;
         rate_step_ff <= RATE_STEP_RST;
         decf_ff      <= DECF_RST;
         qgain_ff     <= QGAIN_RST;
         pgain_ff     <= PGAIN_RST;
         init_sp_ff   <= INIT_SPACING_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CONTROL_MODE:    mode_ff      <= mode_type'(csr_data[1:0]);
            CSR_RATE_STEP:       rate_step_ff <= csr_data[STEPSZ_W-1:0];
            CSR_DECREASE_FACTOR: decf_ff      <= csr_data[DECF_W-1:0];
            CSR_QUEUE_GAIN:      qgain_ff     <= csr_data[GAIN_W-1:0];
            CSR_PLAYBACK_GAIN:   pgain_ff     <= csr_data[GAIN_W-1:0];
            CSR_INITIAL_SPACING: init_sp_ff   <= csr_data[INIT_W-1:0];
            default: ;
         endcase
      end
   end

   // divider operands and saturated quotient
   always_comb begin
      unique case (uc.div_sel)
         DIV_CUR: begin
            div_dividend = NUM_SPACING;
            div_divisor  = spacing_ff;
         end
         DIV_PLAY: begin
            div_dividend = NUM_PLAY;
            div_divisor  = RATE_W'(pspace_ff);
         end
         default: begin
            div_dividend = NUM_SPACING;
            div_divisor  = res_rate_ff;
         end
      endcase
      quo_sat = (|div_quo[NUM_W-1:RATE_W]) ? '1 : div_quo[RATE_W-1:0];
   end

   // shared multiplier operands
   always_comb begin
      q_less    = qnow_ff < qtgt_ff;
      q_more    = qnow_ff > qtgt_ff;
      cur_below = cur_ff < prate_ff;
      unique case (uc.mul_sel)
         MUL_QERR: begin
            mul_a = qgain_ff;
            mul_b = q_less ? RATE_W'(qtgt_ff - qnow_ff) : RATE_W'(qnow_ff - qtgt_ff);
         end
         MUL_PERR: begin
            mul_a = pgain_ff;
            mul_b = cur_below ? (prate_ff - cur_ff) : (cur_ff - prate_ff);
         end
         MUL_DEC: begin
            mul_a = GAIN_W'(decf_ff);
            mul_b = cur_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // rate law
   always_comb begin
      cur_ext  = ACC_W'(cur_ff);
      step_ext = ACC_W'({rate_step_ff, {RATE_FRAC_BITS{1'b0}}});
      e_ext    = q_less ? ACC_W'(emag_ff) : -ACC_W'(emag_ff);
      b_ext    = cur_below ? ACC_W'(bmag_ff) : -ACC_W'(bmag_ff);
      dec_ext  = ACC_W'(dec_ff);
      acc      = cur_ext;
      change   = 1'b1;
      unique case (mode_ff)
         MODE_ADD: begin
            if (q_less) begin
               acc = cur_ext + step_ext;
            end else if (q_more) begin
               acc = cur_ext - step_ext;
            end else begin
               change = 1'b0;
            end
         end
         MODE_AIMD: begin
            if (q_less) begin
               acc = cur_ext + step_ext;
            end else if (q_more) begin
               acc = dec_ext;
            end else begin
               change = 1'b0;
            end
         end
         MODE_PROP: begin
            acc = cur_ext + e_ext;
         end
         default: begin
            acc = cur_ext + e_ext + b_ext;
         end
      endcase
      floored = change && (acc[ACC_W-1] || (acc == '0));
      nr      = (|acc[ACC_W-2:RATE_W]) ? '1 : acc[RATE_W-1:0];
   end

   // datapath register updates
   always_comb begin
      e_wide      = {prod_ff[QPROD_W-1:0], {RATE_FRAC_BITS{1'b0}}};
      spacing_in  = spacing_ff;
      cur_in      = cur_ff;
      prate_in    = prate_ff;
      emag_in     = emag_ff;
      bmag_in     = bmag_ff;
      dec_in      = dec_ff;
      res_rate_in = res_rate_ff;
      res_flag_in = res_flag_ff;
      if ((uc.op == OP_DIV) && div_done) begin
         unique case (uc.div_sel)
            DIV_CUR:  cur_in = quo_sat;
            DIV_PLAY: prate_in = (pspace_ff == '0) ? '0 : quo_sat;
            default:  spacing_in = quo_sat;
         endcase
      end
      if (uc.op == OP_MUL) begin
         unique case (uc.wb_sel)
            WB_EMAG: emag_in = e_wide[QPROD_W+RATE_FRAC_BITS-1:GAIN_FRAC];
            WB_BMAG: bmag_in = prod_ff[PROD_W-1:GAIN_FRAC];
            WB_DEC:  dec_in  = prod_ff[GAIN_FRAC+RATE_W-1:GAIN_FRAC];
            default: ;
         endcase
      end
      if (uc.op == OP_COMBINE) begin
         if (!change) begin
            res_rate_in = cur_ff;
            res_flag_in = 1'b0;
         end else if (floored) begin
            res_rate_in = '0;
            res_flag_in = 1'b1;
            spacing_in  = {{(SPACING_W-INIT_W-SPACING_FRAC){1'b0}}, init_sp_ff,
                           {SPACING_FRAC{1'b0}}};
         end else begin
            res_rate_in = nr;
            res_flag_in = 1'b0;
         end
      end
   end

   // sequencer next step
   always_comb begin
      step_in    = step_ff;
      div_run_in = div_run_ff;
      if (div_start) begin
         div_run_in = 1'b1;
      end else if (div_done) begin
         div_run_in = 1'b0;
      end
      unique case (uc.op)
         OP_WAIT_IN: step_in = in_beat ? step_ff + STEP_W'(1) : step_ff;
         OP_DIV:     step_in = div_done ? step_ff + STEP_W'(1) : step_ff;
         OP_MUL:     step_in = step_ff + STEP_W'(1);
         OP_COMBINE: step_in = (!change || floored) ? uc.jump : step_ff + STEP_W'(1);
         OP_EMIT:    step_in = emit_ok ? uc.jump : step_ff;
         default:    step_in = STEP_IDLE;
      endcase
      if (emit_fire) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= STEP_IDLE;
         div_run_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         spacing_ff    <= SPACING_RST;
      end else begin
         step_ff       <= step_in;
         div_run_ff    <= div_run_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         spacing_ff    <= spacing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_beat) begin
         qnow_ff   <= req_tdata[QUEUE_W-1:0];
         qtgt_ff   <= req_tdata[2*QUEUE_W-1:QUEUE_W];
         pspace_ff <= req_tdata[3*QUEUE_W-1:2*QUEUE_W];
      end
      prod_ff     <= mul_a * mul_b;
      cur_ff      <= cur_in;
      prate_ff    <= prate_in;
      emag_ff     <= emag_in;
      bmag_ff     <= bmag_in;
      dec_ff      <= dec_in;
      res_rate_ff <= res_rate_in;
      res_flag_ff <= res_flag_in;
      if (emit_fire) begin
         rsp_spacing_ff <= spacing_ff;
         rsp_rate_ff    <= res_rate_ff;
         rsp_flag_ff    <= res_flag_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_rate_ff, rsp_spacing_ff};
   assign rsp_tuser  = rsp_flag_ff;

endmodule

// ===== test/send_rate_congestion_update_check.sv =====
// Watches the report, result and register channels of send_rate_congestion_update,
// predicts each new spacing/rate/floor beat and compares it. Depends on srcu_pkg.
`timescale 1ns / 1ps
module send_rate_congestion_update_check #(
   parameter int RATE_FRAC_BITS = srcu_pkg::DEF_RATE_FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [srcu_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [srcu_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             rsp_tuser,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [srcu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [srcu_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic [31:0]                      fail_count,
   output logic [31:0]                      pending,
   output logic [31:0]                      results_checked,
   output logic [31:0]                      floors_seen
);
   import srcu_pkg::*;

   typedef struct packed {
      logic [31:0] spacing_us;
      logic [31:0] rate_pps;
      logic        rate_floored;
   } rate_update_type;

   localparam logic [63:0] SAT32       = 64'hFFFF_FFFF;
   localparam logic [63:0] SPACING_NUM = 64'(MICRO) << (SPACING_FRAC + RATE_FRAC_BITS);
   localparam logic [63:0] PLAY_NUM    = 64'(MICRO) << RATE_FRAC_BITS;

   mode_type            law;
   logic [STEPSZ_W-1:0] step_pps;
   logic [DECF_W-1:0]   decrease_q12;
   logic [GAIN_W-1:0]   qgain;
   logic [GAIN_W-1:0]   pgain;
   logic [INIT_W-1:0]   init_us;
   logic [31:0]         spacing_q8;
   rate_update_type     expected_updates[$];

   function automatic logic [63:0] clip32(logic [63:0] v);
      return (v > SAT32) ? SAT32 : v;
   endfunction

   // Q4.12 gain times a signed value, shifted up, truncated toward zero
   function automatic longint apply_gain(logic [63:0] gain, longint v, int up);
      logic [63:0] mag;
      logic [63:0] p;
      mag = (v < 0) ? 64'(-v) : 64'(v);
      p = ((gain * mag) << up) >> GAIN_FRAC;
      return (v < 0) ? -longint'(p) : longint'(p);
   endfunction

   function automatic rate_update_type next_rate(logic [QUEUE_W-1:0] qn,
                                                 logic [QUEUE_W-1:0] qt,
                                                 logic [19:0] ps);
      logic [63:0]     cur;
      logic [63:0]     prate;
      logic [63:0]     nr;
      longint          r;
      longint          qerr;
      longint          step;
      logic            hold;
      rate_update_type u;
      cur   = (spacing_q8 == 0) ? SAT32 : clip32(SPACING_NUM / 64'(spacing_q8));
      prate = (ps == 0) ? 64'd0 : clip32(PLAY_NUM / 64'(ps));
      step  = longint'(64'(step_pps) << RATE_FRAC_BITS);
      qerr  = longint'(qt) - longint'(qn);
      r     = longint'(cur);
      hold  = 1'b0;
      unique case (law)
         MODE_ADD: begin
            if (qn < qt) r = r + step;
            else if (qn > qt) r = r - step;
            else hold = 1'b1;
         end
         MODE_AIMD: begin
            if (qn < qt) r = r + step;
            else if (qn > qt) r = longint'((cur * 64'(decrease_q12)) >> DECF_W);
            else hold = 1'b1;
         end
         MODE_PROP: begin
            r = r + apply_gain(64'(qgain), qerr, RATE_FRAC_BITS);
         end
         MODE_PROP_PLAY: begin
            r = r + apply_gain(64'(qgain), qerr, RATE_FRAC_BITS);
            r = r - apply_gain(64'(pgain), longint'(cur) - longint'(prate), 0);
         end
      endcase
      if (hold) begin
         u.spacing_us   = spacing_q8;
         u.rate_pps     = cur[31:0];
         u.rate_floored = 1'b0;
      end else if (r <= 0) begin
         u.spacing_us   = {4'd0, init_us, 8'd0};
         u.rate_pps     = 32'd0;
         u.rate_floored = 1'b1;
      end else begin
         nr             = clip32(64'(r));
         u.rate_pps     = nr[31:0];
         nr             = clip32(SPACING_NUM / nr);
         u.spacing_us   = nr[31:0];
         u.rate_floored = 1'b0;
      end
      return u;
   endfunction

   always @(posedge clock) begin : track
      rate_update_type want;
      rate_update_type got;
      int              bad;
      bad = 0;
      if (reset) begin
         law          <= MODE_ADD;
         step_pps     <= RATE_STEP_RST;
         decrease_q12 <= DECF_RST;
         qgain        <= QGAIN_RST;
         pgain        <= PGAIN_RST;
         init_us      <= INIT_SPACING_RST;
         spacing_q8   <= SPACING_RST;
         expected_updates.delete();
         fail_count      <= 0;
         pending         <= 0;
         results_checked <= 0;
         floors_seen     <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_CONTROL_MODE:    law          <= mode_type'(csr_data[1:0]);
               CSR_RATE_STEP:       step_pps     <= csr_data[STEPSZ_W-1:0];
               CSR_DECREASE_FACTOR: decrease_q12 <= csr_data[DECF_W-1:0];
               CSR_QUEUE_GAIN:      qgain        <= csr_data[GAIN_W-1:0];
               CSR_PLAYBACK_GAIN:   pgain        <= csr_data[GAIN_W-1:0];
               CSR_INITIAL_SPACING: init_us      <= csr_data[INIT_W-1:0];
               default: ;
            endcase
         end
         // pop before push so a stray beat never matches the report taken this edge
         if (rsp_tvalid && rsp_tready) begin
            got.spacing_us   = rsp_tdata[31:0];
            got.rate_pps     = rsp_tdata[63:32];
            got.rate_floored = rsp_tuser;
            if (expected_updates.size() == 0) begin
               $error("result beat with nothing expected: spacing %0d rate %0d floored %0d",
                      got.spacing_us, got.rate_pps, got.rate_floored);
               bad++;
            end else begin
               want = expected_updates.pop_front();
               if (got.spacing_us !== want.spacing_us) begin
                  $error("spacing_us: expected %0d, got %0d", want.spacing_us, got.spacing_us);
                  bad++;
               end
               if (got.rate_pps !== want.rate_pps) begin
                  $error("rate_pps: expected %0d, got %0d", want.rate_pps, got.rate_pps);
                  bad++;
               end
               if (got.rate_floored !== want.rate_floored) begin
                  $error("rate_floored: expected %0d, got %0d",
                         want.rate_floored, got.rate_floored);
                  bad++;
               end
               results_checked <= results_checked + 1;
               if (want.rate_floored) floors_seen <= floors_seen + 1;
            end
         end
         if (req_tvalid && req_tready) begin
            want = next_rate(req_tdata[19:0], req_tdata[39:20], req_tdata[59:40]);
            expected_updates.push_back(want);
            spacing_q8 <= want.spacing_us;
         end
         fail_count <= fail_count + bad;
         pending    <= expected_updates.size();
      end
   end

endmodule

// ===== test/send_rate_congestion_update_tb.sv =====
// Stimulus and verdict for send_rate_congestion_update: register settings, feedback reports,
// idle and stall profiles. Uses srcu_pkg, the design and send_rate_congestion_update_check.
`timescale 1ns / 1ps
module send_rate_congestion_update_tb;
   import srcu_pkg::*;

   localparam logic [QUEUE_W-1:0] QMAX        = 20'hFFFFF;
   localparam logic [19:0]        PS_MAX      = 20'd1000000;
   localparam int                 HOLD_CYCLES = 1500;
   localparam int                 PHASES      = 14;
   localparam int                 PHASE_ITEMS = 125;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   logic [31:0] fail_count;
   logic [31:0] pending;
   logic [31:0] results_checked;
   logic [31:0] floors_seen;

   int   tx_idle_pct = 0;
   int   rx_stall_pct = 0;
   logic hold_start = 1'b0;
   int   hold_left = 0;
   int   reports_sent = 0;
   int   settings_used = 1;

   always #5 clock = ~clock;

   send_rate_congestion_update uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   send_rate_congestion_update_check rate_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_checked (results_checked),
      .floors_seen     (floors_seen)
   );

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else if (hold_start) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   // leaves csr_valid high; caller lowers it after the last write
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [19:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic send_report(input logic [QUEUE_W-1:0] qn, input logic [QUEUE_W-1:0] qt,
                              input logic [19:0] ps);
      int gap;
      gap = 0;
      if ($urandom_range(99) < tx_idle_pct) gap = $urandom_range(1, 200);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'h0, ps, qt, qn};
      do @(posedge clock); while (!req_tready);
      reports_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic random_report();
      logic [QUEUE_W-1:0] qn;
      logic [QUEUE_W-1:0] qt;
      logic [19:0]        ps;
      int                 k;
      int                 d;
      int                 t;
      qn = QUEUE_W'($urandom());
      qt = QUEUE_W'($urandom());
      k  = $urandom_range(99);
      if (k < 15) begin
         qt = qn;
      end else if (k < 70) begin
         d = int'($urandom_range(600)) - 300;
         t = int'(qn) + d;
         if (t < 0) t = 0;
         if (t > int'(QMAX)) t = int'(QMAX);
         qt = QUEUE_W'(t);
      end else if (k >= 85) begin
         case ($urandom_range(2))
            0: qn = '0;
            1: qn = QMAX;
            default: ;
         endcase
         case ($urandom_range(2))
            0: qt = '0;
            1: qt = QMAX;
            default: ;
         endcase
      end
      k = $urandom_range(99);
      if (k < 20) ps = '0;
      else if (k < 25) ps = 20'd1;
      else if (k < 30) ps = PS_MAX;
      else if (k < 60) ps = 20'($urandom_range(1, 200000));
      else ps = 20'($urandom_range(1, 1000000));
      send_report(qn, qt, ps);
   endtask

   task automatic random_settings(input int ph);
      logic [19:0] v;
      write_reg(CSR_CONTROL_MODE, 20'((ph + ph / 4) % 4));
      case ($urandom_range(3))
         0: v = 20'd0;
         1: v = 20'd1023;
         2: v = 20'($urandom_range(1, 16));
         default: v = 20'($urandom_range(1023));
      endcase
      write_reg(CSR_RATE_STEP, v);
      case ($urandom_range(2))
         0: v = 20'd0;
         1: v = 20'd4095;
         default: v = 20'($urandom_range(4095));
      endcase
      write_reg(CSR_DECREASE_FACTOR, v);
      case ($urandom_range(3))
         0: v = 20'd0;
         1: v = 20'd65535;
         2: v = 20'($urandom_range(8192));
         default: v = 20'($urandom_range(65535));
      endcase
      write_reg(CSR_QUEUE_GAIN, v);
      case ($urandom_range(3))
         0: v = 20'd0;
         1: v = 20'd65535;
         2: v = 20'($urandom_range(8192));
         default: v = 20'($urandom_range(65535));
      endcase
      write_reg(CSR_PLAYBACK_GAIN, v);
      case ($urandom_range(3))
         0: v = 20'd1;
         1: v = PS_MAX;
         2: v = 20'($urandom_range(1000, 200000));
         default: v = 20'($urandom_range(1, 1000000));
      endcase
      write_reg(CSR_INITIAL_SPACING, v);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int ph;
      int n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: additive law, step of one
      send_report('0, '0, '0);
      send_report('0, QMAX, PS_MAX);
      send_report(QMAX, '0, 20'd1);
      send_report(QMAX, QMAX, 20'd524288);
      drain();

      // largest additive step: decrease floors the rate, increase recovers
      write_reg(CSR_RATE_STEP, 20'd1023);
      csr_valid <= 1'b0;
      settings_used++;
      send_report(20'd500, 20'd100, 20'd40000);
      send_report(20'd100, 20'd500, 20'd40000);
      drain();

      // multiplicative decrease at full factor
      write_reg(CSR_CONTROL_MODE, 20'(MODE_AIMD));
      write_reg(CSR_DECREASE_FACTOR, 20'd4095);
      csr_valid <= 1'b0;
      settings_used++;
      send_report(20'd10, 20'd20, 20'd0);
      send_report(20'd20, 20'd10, 20'd0);
      send_report(20'd20, 20'd20, 20'd0);
      drain();

      // proportional law at full gain: saturate, floor, zero error
      write_reg(CSR_CONTROL_MODE, 20'(MODE_PROP));
      write_reg(CSR_QUEUE_GAIN, 20'd65535);
      csr_valid <= 1'b0;
      settings_used++;
      send_report('0, QMAX, 20'd1000);
      send_report(QMAX, '0, 20'd1000);
      send_report(20'd777, 20'd777, 20'd1000);
      drain();

      // playback pull: no playback rate, saturated playback rate, slow playback
      write_reg(CSR_CONTROL_MODE, 20'(MODE_PROP_PLAY));
      write_reg(CSR_QUEUE_GAIN, 20'd410);
      write_reg(CSR_PLAYBACK_GAIN, 20'd65535);
      csr_valid <= 1'b0;
      settings_used++;
      send_report(20'd300, 20'd300, '0);
      send_report(20'd300, 20'd300, 20'd1);
      send_report(20'd300, 20'd310, PS_MAX);
      send_report(20'd310, 20'd300, 20'd20000);
      drain();

      // zero fallback spacing: floor to zero spacing, hold, then increase from saturation
      write_reg(CSR_CONTROL_MODE, 20'(MODE_AIMD));
      write_reg(CSR_DECREASE_FACTOR, 20'd0);
      write_reg(CSR_INITIAL_SPACING, 20'd0);
      csr_valid <= 1'b0;
      settings_used++;
      send_report(20'd9, 20'd5, 20'd100);
      send_report(20'd5, 20'd5, 20'd100);
      send_report(20'd5, 20'd9, 20'd100);
      drain();

      for (ph = 0; ph < PHASES; ph++) begin
         case (ph % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 64; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 64; end
            default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
         endcase
         random_settings(ph);
         if (ph == 4) begin
            hold_start <= 1'b1;
            @(posedge clock);
            hold_start <= 1'b0;
         end
         for (n = 0; n < PHASE_ITEMS; n++) random_report();
         drain();
      end

      repeat (200) @(posedge clock);
      $display("Sent %0d feedback reports under %0d register settings over all four laws.",
               reports_sent, settings_used);
      $display("Compared %0d results, %0d of them with the rate floored.",
               results_checked, floors_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== send_rate_congestion_update.f =====
rtl/core/srcu_pkg.sv
rtl/core/srcu_ucode_rom.sv
rtl/core/srcu_divider.sv
rtl/core/send_rate_congestion_update.sv
test/send_rate_congestion_update_check.sv
test/send_rate_congestion_update_tb.sv
